// File: rtl/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error("forbidden condition");
`endif

// File: rtl/apd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apd_pkg
// Constants and types shared by the aging priority dispatcher.
// ---------------------------------------------------------------------------
package apd_pkg;
	localparam int SLOTS     = 128;
	localparam int SERVERS   = 4;
	localparam int AGE_WIDTH = 16;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int SRV_W     = $clog2(SERVERS);
	localparam int CNT_W     = $clog2(SLOTS + 1);

	localparam logic [1:0] CLS_CRITICAL = 2'd0;
	localparam logic [1:0] CLS_SERIOUS  = 2'd1;
	localparam logic [1:0] CLS_NORMAL   = 2'd2;

	localparam logic [1:0] REQ_ENQ  = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_DISP = 2'd2;

	localparam logic [2:0] ST_ENQ     = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_TICK    = 3'd2;
	localparam logic [2:0] ST_GRANT   = 3'd3;
	localparam logic [2:0] ST_NONE    = 3'd4;

	localparam logic [1:0] CFG_AGING   = 2'd0;
	localparam logic [1:0] CFG_TRIGGER = 2'd1;
	localparam logic [1:0] CFG_FATIGUE = 2'd2;
	localparam logic [1:0] CFG_SENIOR  = 2'd3;

	typedef struct packed {
		logic [1:0]           cls;
		logic [AGE_WIDTH-1:0] age;
		logic [15:0]          ident;
	} slot_t;
endpackage

// File: rtl/aging_priority_dispatcher.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aging_priority_dispatcher
// Three-class dispatcher with aging over a slot memory.
// ---------------------------------------------------------------------------
// Usage: one input item (req_type, item_id, item_class, server_id) on a
// valid/ready channel yields one result item on a valid/ready output channel.
// Configuration is a write port (cfg_we, cfg_idx, cfg_wdata), written idle.
// Enqueue and an unknown request offer their result straight after the decode
// state, where the free slot comes from a priority pick over the valid bits.
// Tick and dispatch offer theirs after the decode state, one walk of the slot
// memory through its single read port, one slot a cycle, with a pipeline
// register on the read, and a state for the serious promotion or the grant.
// A tick ages and promotes during the walk. After the result handshake the
// block returns to idle before it accepts the next item.
// One item is in work at a time; ready is low from accept until the result
// is taken. If the receiver stalls, the result is held and nothing more is
// accepted. Reset empties all slots and streaks and loads default config.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module aging_priority_dispatcher import apd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] item_id,
	input  logic [1:0]  item_class,
	input  logic [1:0]  server_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] grant_id,
	output logic [1:0]  grant_class,
	output logic [7:0]  server_streak,
	output logic [7:0]  promoted_count,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DEC   = 7'b0000010,
		S_TICK  = 7'b0000100,
		S_SER   = 7'b0001000,
		S_DISP  = 7'b0010000,
		S_GRANT = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [15:0] aging_q;
	logic [7:0]  trig_q, fat_q;
	logic [2:0]  senior_q;
	logic [SLOTS-1:0] valid_q;
	logic [7:0]  streak_q [SERVERS];
	slot_t       mem [SLOTS];
	slot_t       rd_s1;

	logic [1:0]  req_q, icls_q;
	logic [15:0] iid_q;
	logic [1:0]  srv_q;
	logic [SLOT_W:0] rcnt_q;      // read address counter
	logic [SLOT_W-1:0] idx_s1;
	logic        rv_s1;
	logic [CNT_W-1:0] sercnt_q;
	logic [7:0]  prom_q;
	logic        bv_q [3];
	logic [SLOT_W-1:0] bi_q [3];
	logic [AGE_WIDTH-1:0] ba_q [3];
	logic [15:0] bid_q [3];
	logic [2:0]  st_q;
	logic [15:0] gid_q;
	logic [1:0]  gcls_q;
	logic [7:0]  gstr_q;

	logic              mem_we;
	logic [SLOT_W-1:0] mem_wa;
	slot_t             mem_wd;
	logic [SLOT_W-1:0] free_idx;
	logic              free_any;
	logic [AGE_WIDTH-1:0] nage;
	logic              fatigued, senior;
	logic [1:0]        pick;
	logic              pick_ok;
	logic              ser_promo;
	logic [7:0]        str_next;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = st_q;
	assign grant_id = gid_q;
	assign grant_class = gcls_q;
	assign server_streak = gstr_q;
	assign promoted_count = prom_q;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign nage = (rd_s1.age == {AGE_WIDTH{1'b1}}) ? rd_s1.age : rd_s1.age + 1'b1;
	assign fatigued = streak_q[srv_q] >= fat_q;
	assign senior = {1'b0, srv_q} < senior_q;
	assign ser_promo = ({{(32-CNT_W){1'b0}}, sercnt_q} >= {24'd0, trig_q})
		&& bv_q[CLS_SERIOUS];

	always_comb begin
		pick = CLS_CRITICAL;
		pick_ok = 1'b0;
		if (fatigued) begin
			if (bv_q[CLS_SERIOUS]) begin
				pick = CLS_SERIOUS; pick_ok = 1'b1;
			end else if (senior && bv_q[CLS_CRITICAL]) begin
				pick = CLS_CRITICAL; pick_ok = 1'b1;
			end
		end else begin
			if (senior && bv_q[CLS_CRITICAL]) begin
				pick = CLS_CRITICAL; pick_ok = 1'b1;
			end else if (bv_q[CLS_SERIOUS]) begin
				pick = CLS_SERIOUS; pick_ok = 1'b1;
			end else if (bv_q[CLS_NORMAL]) begin
				pick = CLS_NORMAL; pick_ok = 1'b1;
			end
		end
	end

	always_comb begin
		str_next = streak_q[srv_q];
		if (pick_ok) begin
			if (pick != CLS_NORMAL) begin
				str_next = '0;
			end else if (str_next != 8'hff) begin
				str_next = str_next + 1'b1;
			end
		end
	end

	// slot write: enqueue into the free slot, tick write-back of the slot in rd_s1, serious promotion
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_s1;
		mem_wd = rd_s1;
		case (state_q)
			S_DEC: begin
				mem_we = free_any && (req_q == REQ_ENQ);
				mem_wa = free_idx;
				mem_wd.cls = (icls_q == 2'd3) ? CLS_NORMAL : icls_q;
				mem_wd.age = '0;
				mem_wd.ident = iid_q;
			end
			S_TICK: begin
				mem_we = rv_s1 && valid_q[idx_s1];
				mem_wd.age = nage;
				if ({{(32-AGE_WIDTH){1'b0}}, nage} >= {16'd0, aging_q})
					mem_wd.cls = CLS_CRITICAL;
			end
			S_SER: begin
				mem_we = ser_promo;
				mem_wa = bi_q[CLS_SERIOUS];
				mem_wd.cls = CLS_CRITICAL;
				mem_wd.age = ba_q[CLS_SERIOUS];
				mem_wd.ident = bid_q[CLS_SERIOUS];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[rcnt_q[SLOT_W-1:0]];
		idx_s1 <= rcnt_q[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			aging_q <= 16'd30;
			trig_q <= 8'd5;
			fat_q <= 8'd3;
			senior_q <= 3'd2;
			valid_q <= '0;
			for (int s = 0; s < SERVERS; s++) streak_q[s] <= '0;
			rv_s1 <= 1'b0;
			rcnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_AGING:   aging_q <= cfg_wdata;
					CFG_TRIGGER: trig_q <= cfg_wdata[7:0];
					CFG_FATIGUE: fat_q <= cfg_wdata[7:0];
					CFG_SENIOR:  senior_q <= cfg_wdata[2:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DEC;
						req_q <= req_type;
						iid_q <= item_id;
						icls_q <= item_class;
						srv_q <= server_id;
						rcnt_q <= '0;
						rv_s1 <= 1'b0;
					end
				end
				S_DEC: begin
					gid_q <= '0; gcls_q <= '0; gstr_q <= '0; prom_q <= '0;
					sercnt_q <= '0;
					for (int c = 0; c < 3; c++) begin
						bv_q[c] <= 1'b0; bi_q[c] <= '0; ba_q[c] <= '0; bid_q[c] <= '0;
					end
					rcnt_q <= '0;
					rv_s1 <= 1'b0;
					case (req_q)
						REQ_ENQ: begin
							st_q <= free_any ? ST_ENQ : ST_FULL;
							if (free_any) valid_q[free_idx] <= 1'b1;
							state_q <= S_OUT;
						end
						REQ_TICK: begin
							st_q <= ST_TICK;
							state_q <= S_TICK;
						end
						REQ_DISP: begin
							st_q <= ST_NONE;
							state_q <= ({{(32-SRV_W){1'b0}}, srv_q} < SERVERS) ? S_DISP : S_OUT;
						end
						default: begin
							st_q <= ST_NONE;
							state_q <= S_OUT;
						end
					endcase
				end
				S_TICK: begin
					if (rcnt_q < (SLOT_W+1)'(SLOTS)) rcnt_q <= rcnt_q + 1'b1;
					rv_s1 <= rcnt_q < (SLOT_W+1)'(SLOTS);
					if (rv_s1 && valid_q[idx_s1]) begin
						if (rd_s1.cls != CLS_CRITICAL && mem_wd.cls == CLS_CRITICAL)
							prom_q <= prom_q + 1'b1;
						if (mem_wd.cls == CLS_SERIOUS) begin
							sercnt_q <= sercnt_q + 1'b1;
							if (!bv_q[CLS_SERIOUS] || nage > ba_q[CLS_SERIOUS]) begin
								bv_q[CLS_SERIOUS] <= 1'b1;
								bi_q[CLS_SERIOUS] <= idx_s1;
								ba_q[CLS_SERIOUS] <= nage;
								bid_q[CLS_SERIOUS] <= rd_s1.ident;
							end
						end
					end
					if (rv_s1 && idx_s1 == SLOT_W'(SLOTS - 1)) state_q <= S_SER;
				end
				S_SER: begin
					if (ser_promo) prom_q <= prom_q + 1'b1;
					state_q <= S_OUT;
				end
				S_DISP: begin
					if (rcnt_q < (SLOT_W+1)'(SLOTS)) rcnt_q <= rcnt_q + 1'b1;
					rv_s1 <= rcnt_q < (SLOT_W+1)'(SLOTS);
					if (rv_s1 && valid_q[idx_s1] && rd_s1.cls != 2'd3) begin
						if (!bv_q[rd_s1.cls] || rd_s1.age > ba_q[rd_s1.cls]) begin
							bv_q[rd_s1.cls] <= 1'b1;
							bi_q[rd_s1.cls] <= idx_s1;
							ba_q[rd_s1.cls] <= rd_s1.age;
							bid_q[rd_s1.cls] <= rd_s1.ident;
						end
					end
					if (rv_s1 && idx_s1 == SLOT_W'(SLOTS - 1)) state_q <= S_GRANT;
				end
				S_GRANT: begin
					st_q <= pick_ok ? ST_GRANT : ST_NONE;
					if (pick_ok) begin
						valid_q[bi_q[pick]] <= 1'b0;
						gid_q <= bid_q[pick];
						gcls_q <= pick;
					end
					streak_q[srv_q] <= str_next;
					gstr_q <= str_next;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_state_onehot, $onehot(state_q))
	`ASSERT_NEVER(a_in_out_excl, in_ready && out_valid)
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(grant_id) && $stable(server_streak) && $stable(promoted_count))
	`ASSERT_NEVER(a_status_range, out_valid && status > ST_NONE)
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the aging priority dispatcher. A driver and a
// monitor work on valid/ready channels with random idling on both sides.
// The bench keeps its own model of the slot table, the streaks and the
// configuration, and compares every result field by field with it.
// ---------------------------------------------------------------------------
module tb_top import apd_pkg::*;;

	typedef struct packed {
		logic [1:0]  req;
		logic [15:0] ident;
		logic [1:0]  cls;
		logic [1:0]  srv;
	} disp_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] gid;
		logic [1:0]  gcls;
		logic [7:0]  streak;
		logic [7:0]  promoted;
	} disp_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [15:0] item_id;
	logic [1:0]  item_class;
	logic [1:0]  server_id;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [15:0] grant_id;
	logic [1:0]  grant_class;
	logic [7:0]  server_streak;
	logic [7:0]  promoted_count;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_wdata;

	disp_req_t pending_reqs[$];
	disp_rsp_t expected_rsps[$];
	int        send_idle_pct;
	int        recv_idle_pct;
	int        n_errors;
	int        n_results;
	int        n_grants;
	int        n_full;
	int        n_promoted;

	// dispatcher model state
	logic [15:0]          m_aging;
	logic [7:0]           m_trigger;
	logic [7:0]           m_fatigue;
	logic [2:0]           m_senior;
	logic                 m_valid[SLOTS];
	logic [1:0]           m_cls[SLOTS];
	logic [AGE_WIDTH-1:0] m_age[SLOTS];
	logic [15:0]          m_ident[SLOTS];
	logic [7:0]           m_streak[SERVERS];

	aging_priority_dispatcher i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .item_id(item_id), .item_class(item_class),
		.server_id(server_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .grant_id(grant_id), .grant_class(grant_class),
		.server_streak(server_streak), .promoted_count(promoted_count),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int oldest_of(logic [1:0] c);
		int best;
		best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (m_valid[i] && m_cls[i] == c && (best < 0 || m_age[i] > m_age[best])) begin
				best = i;
			end
		end
		return best;
	endfunction

	function automatic int live_count();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (m_valid[i]) begin
				n++;
			end
		end
		return n;
	endfunction

	function automatic disp_rsp_t dispatch_predict(disp_req_t r);
		disp_rsp_t o;
		int        slot;
		int        ser_cnt;
		logic      senior;
		o = '0;
		o.status = ST_NONE;
		case (r.req)
			REQ_ENQ: begin
				slot = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (!m_valid[i] && slot < 0) begin
						slot = i;
					end
				end
				if (slot < 0) begin
					o.status = ST_FULL;
				end else begin
					m_valid[slot] = 1'b1;
					m_cls[slot] = (r.cls > CLS_NORMAL) ? CLS_NORMAL : r.cls;
					m_age[slot] = '0;
					m_ident[slot] = r.ident;
					o.status = ST_ENQ;
				end
			end
			REQ_TICK: begin
				ser_cnt = 0;
				for (int i = 0; i < SLOTS; i++) begin
					if (m_valid[i]) begin
						if (m_age[i] != '1) begin
							m_age[i] = m_age[i] + 1'b1;
						end
						if (m_age[i] >= m_aging && m_cls[i] != CLS_CRITICAL) begin
							m_cls[i] = CLS_CRITICAL;
							o.promoted++;
						end
						if (m_cls[i] == CLS_SERIOUS) begin
							ser_cnt++;
						end
					end
				end
				if (ser_cnt >= m_trigger) begin
					slot = oldest_of(CLS_SERIOUS);
					if (slot >= 0) begin
						m_cls[slot] = CLS_CRITICAL;
						o.promoted++;
					end
				end
				o.status = ST_TICK;
			end
			REQ_DISP: begin
				senior = r.srv < m_senior;
				slot = -1;
				if (m_streak[r.srv] >= m_fatigue) begin
					slot = oldest_of(CLS_SERIOUS);
					if (slot < 0 && senior) begin
						slot = oldest_of(CLS_CRITICAL);
					end
				end else begin
					if (senior) begin
						slot = oldest_of(CLS_CRITICAL);
					end
					if (slot < 0) begin
						slot = oldest_of(CLS_SERIOUS);
					end
					if (slot < 0) begin
						slot = oldest_of(CLS_NORMAL);
					end
				end
				if (slot >= 0) begin
					m_valid[slot] = 1'b0;
					o.gid = m_ident[slot];
					o.gcls = m_cls[slot];
					if (m_cls[slot] == CLS_NORMAL) begin
						if (m_streak[r.srv] != 8'hff) begin
							m_streak[r.srv]++;
						end
					end else begin
						m_streak[r.srv] = '0;
					end
					o.status = ST_GRANT;
				end
				o.streak = m_streak[r.srv];
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= '0;
			item_id <= '0;
			item_class <= '0;
			server_id <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				expected_rsps.push_back(dispatch_predict({req_type, item_id, item_class, server_id}));
			end
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				{req_type, item_id, item_class, server_id} <= pending_reqs.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_rsps.size() == 0) begin
					$error("unexpected result, status %0d", status);
					n_errors++;
				end else begin
					disp_rsp_t e;
					e = expected_rsps.pop_front();
					if (e.status == ST_GRANT) n_grants++;
					if (e.status == ST_FULL) n_full++;
					n_promoted += e.promoted;
					if (status !== e.status) begin
						$error("status exp %0d got %0d", e.status, status);
						n_errors++;
					end
					if (grant_id !== e.gid) begin
						$error("grant_id exp %0d got %0d", e.gid, grant_id);
						n_errors++;
					end
					if (grant_class !== e.gcls) begin
						$error("grant_class exp %0d got %0d", e.gcls, grant_class);
						n_errors++;
					end
					if (server_streak !== e.streak) begin
						$error("server_streak exp %0d got %0d", e.streak, server_streak);
						n_errors++;
					end
					if (promoted_count !== e.promoted) begin
						$error("promoted_count exp %0d got %0d", e.promoted, promoted_count);
						n_errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_req(logic [1:0] rq, logic [15:0] id, logic [1:0] c, logic [1:0] s);
		pending_reqs.push_back({rq, id, c, s});
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0) begin
			@(posedge clk);
		end
		repeat (4 * SLOTS + 20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_AGING: m_aging = val;
			CFG_TRIGGER: m_trigger = val[7:0];
			CFG_FATIGUE: m_fatigue = val[7:0];
			default: m_senior = val[2:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed traffic: enqueues, ticks and dispatches, with fill extra enqueues after every sixtieth item.
	task automatic random_traffic(int n, int fill);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 2) begin
				push_req(2'd3, 16'($urandom), 2'($urandom), 2'($urandom));
			end else if (r < 40) begin
				push_req(REQ_ENQ, 16'($urandom), 2'($urandom), 2'($urandom));
			end else if (r < 65) begin
				push_req(REQ_TICK, 16'($urandom), 2'($urandom), 2'($urandom));
			end else begin
				push_req(REQ_DISP, 16'($urandom), 2'($urandom), 2'($urandom));
			end
			if (k % 60 == 59) begin
				for (int j = 0; j < fill; j++) begin
					push_req(REQ_ENQ, 16'($urandom), 2'($urandom_range(2)), 2'($urandom));
				end
			end
		end
	endtask

	initial begin
		n_errors = 0;
		n_results = 0;
		n_grants = 0;
		n_full = 0;
		n_promoted = 0;
		send_idle_pct = 23;
		recv_idle_pct = 85;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		m_aging = 16'd30;
		m_trigger = 8'd5;
		m_fatigue = 8'd3;
		m_senior = 3'd2;
		for (int i = 0; i < SLOTS; i++) begin
			m_valid[i] = 1'b0;
			m_cls[i] = '0;
			m_age[i] = '0;
			m_ident[i] = '0;
		end
		for (int i = 0; i < SERVERS; i++) begin
			m_streak[i] = '0;
		end
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: defaults, class three, bad request, empty dispatch, fatigue
		push_req(REQ_DISP, 16'h0000, CLS_CRITICAL, 2'd0);
		push_req(REQ_ENQ, 16'hffff, CLS_CRITICAL, 2'd3);
		push_req(REQ_ENQ, 16'h0000, CLS_SERIOUS, 2'd0);
		push_req(REQ_ENQ, 16'h1234, 2'd3, 2'd1);
		push_req(REQ_ENQ, 16'h5555, CLS_NORMAL, 2'd2);
		push_req(REQ_ENQ, 16'haaaa, CLS_NORMAL, 2'd0);
		push_req(REQ_ENQ, 16'h0f0f, CLS_NORMAL, 2'd0);
		push_req(2'd3, 16'hffff, 2'd3, 2'd3);
		push_req(REQ_TICK, 16'h0, CLS_CRITICAL, 2'd0);
		push_req(REQ_DISP, 16'h0, CLS_CRITICAL, 2'd3);
		push_req(REQ_DISP, 16'h0, CLS_CRITICAL, 2'd3);
		push_req(REQ_DISP, 16'h0, CLS_CRITICAL, 2'd3);
		push_req(REQ_DISP, 16'h0, CLS_CRITICAL, 2'd3);
		push_req(REQ_DISP, 16'h0, CLS_CRITICAL, 2'd2);
		push_req(REQ_DISP, 16'h0, CLS_CRITICAL, 2'd0);
		push_req(REQ_DISP, 16'h0, CLS_CRITICAL, 2'd1);
		drain();

		// fill to full, then overflow, under extreme config
		write_reg(CFG_AGING, 16'd1);
		write_reg(CFG_TRIGGER, 16'd1);
		write_reg(CFG_FATIGUE, 16'd1);
		write_reg(CFG_SENIOR, 16'd0);
		for (int i = 0; i < SLOTS + 2; i++) begin
			push_req(REQ_ENQ, 16'($urandom), 2'($urandom), 2'($urandom));
		end
		push_req(REQ_TICK, 16'h0, CLS_CRITICAL, 2'd0);
		random_traffic(200, 2);
		drain();

		send_idle_pct = 85;
		recv_idle_pct = 23;
		write_reg(CFG_AGING, 16'hffff);
		write_reg(CFG_TRIGGER, 16'd128);
		write_reg(CFG_FATIGUE, 16'd255);
		write_reg(CFG_SENIOR, 16'd4);
		random_traffic(350, 6);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_AGING, 16'd0);
		write_reg(CFG_TRIGGER, 16'd0);
		write_reg(CFG_FATIGUE, 16'd0);
		write_reg(CFG_SENIOR, 16'd7);
		random_traffic(150, 4);
		drain();

		write_reg(CFG_AGING, 16'd12);
		write_reg(CFG_TRIGGER, 16'd4);
		write_reg(CFG_FATIGUE, 16'd2);
		write_reg(CFG_SENIOR, 16'd1);
		random_traffic(250, 5);
		drain();

		$display("covered %0d results: %0d grants, %0d full-table answers, %0d promotions",
			n_results, n_grants, n_full, n_promoted);
		$display("four configuration settings incl. extremes, %0d slots live at end",
			live_count());
		if (n_errors == 0 && expected_rsps.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl
rtl/apd_pkg.sv
rtl/aging_priority_dispatcher.sv
tb/tb_top.sv
